// File: src/tks_pkg.sv
// Shared types for the top-K selector: one kept entry and the chain commands.
// No dependencies.
`default_nettype none

package tks_pkg;

  localparam int unsigned IdW    = 10;
  localparam int unsigned ScoreW = 16;

  typedef struct packed {
    logic                     valid;
    logic [IdW-1:0]           id;
    logic signed [ScoreW-1:0] score;
  } entry_t;

  // Command broadcast to every cell in the chain
  typedef struct packed {
    logic insert;  // offer the incoming item
    logic drain;   // shift every entry one place towards cell 0
  } ctrl_t;

endpackage

`default_nettype wire

// File: src/tks_if.sv
// Valid/ready channel interfaces for the top-K selector's input and result items.
// Depends on nothing but the fixed field widths.
`default_nettype none

interface tks_in_if;
  logic               valid;
  logic               ready;
  logic [9:0]         place_id;
  logic signed [15:0] score;
  logic               last;

  modport source (output valid, output place_id, output score, output last, input ready);
  modport sink   (input valid, input place_id, input score, input last, output ready);
endinterface

interface tks_out_if;
  logic               valid;
  logic               ready;
  logic [9:0]         out_id;
  logic signed [15:0] out_score;
  logic               out_last;

  modport source (output valid, output out_id, output out_score, output out_last, input ready);
  modport sink   (input valid, input out_id, input out_score, input out_last, output ready);
endinterface

`default_nettype wire

// File: src/tks_cell.sv
// One cell of the sorted chain: holds one entry, compares, inserts or shifts.
// Depends on tks_pkg.
`default_nettype none

module tks_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire tks_pkg::ctrl_t ctrl,
  input  wire tks_pkg::entry_t new_item,
  input  wire tks_pkg::entry_t prev_entry,  // neighbour nearer the head
  input  wire logic           prev_take,
  input  wire tks_pkg::entry_t next_entry,  // neighbour nearer the tail
  output tks_pkg::entry_t     entry_o,
  output logic                take_o
);

  tks_pkg::entry_t entry_r;

  // strictly greater: ties stay behind the kept entry
  assign take_o  = !entry_r.valid || (new_item.score > entry_r.score);
  assign entry_o = entry_r;

  // reset clears the valid bit only; id and score hold until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (ctrl.drain) begin
      entry_r <= next_entry;
    end else if (ctrl.insert && take_o) begin
      entry_r <= prev_take ? prev_entry : new_item;
    end
  end

endmodule

`default_nettype wire

// File: src/top_k_select_by_score_top.sv
// Top-K selector: chain of TOP_K sorted cells plus load/drain control.
// Loading: one item accepted per cycle, inserted in the cycle it is taken.
// After the last item of a run: kept items leave best first, one per cycle
// while out_ch.ready is high; the first is registered once the output register is free.
// Input stalls during the drain.
// Synchronous active-low reset clears all cell valid bits and the output valid bit.
`default_nettype none

module top_k_select_by_score_top #(
  parameter int unsigned TOP_K = 10
) (
  input  wire logic clk,
  input  wire logic rst_n,
  tks_in_if.sink    in_ch,
  tks_out_if.source out_ch
);

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  state_t state_r;

  logic               out_valid_r;
  logic [9:0]         out_id_r;
  logic signed [15:0] out_score_r;
  logic               out_last_r;

  // entries[TOP_K] is a permanently empty slot behind the tail cell
  tks_pkg::entry_t entries [TOP_K+1];
  logic            takes   [TOP_K];
  tks_pkg::entry_t new_item;
  tks_pkg::ctrl_t  ctrl;

  logic in_fire;
  logic out_free;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign ctrl.insert = in_fire;
  assign ctrl.drain  = (state_r == ST_DRAIN) && out_free;

  assign new_item.valid = 1'b1;
  assign new_item.id    = in_ch.place_id;
  assign new_item.score = in_ch.score;

  assign entries[TOP_K] = '0;

  // The chain: cell i takes the new item if it is the first to beat,
  // or its upper neighbour's entry if that neighbour also takes.
  for (genvar i = 0; i < TOP_K; i++) begin : g_cell
    tks_pkg::entry_t prev_e;
    logic            prev_t;

    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_t = 1'b0;
    end else begin : g_body
      assign prev_e = entries[i-1];
      assign prev_t = takes[i-1];
    end

    tks_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_item   (new_item),
      .prev_entry (prev_e),
      .prev_take  (prev_t),
      .next_entry (entries[i+1]),
      .entry_o    (entries[i]),
      .take_o     (takes[i])
    );
  end

  // Control and output register. Head cell is always valid while draining:
  // the last item of a run has been offered, so at least one is kept.
  // While loading, a waiting result simply leaves once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_LOAD: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
          end
          if (in_fire && in_ch.last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_id_r    <= entries[0].id;
            out_score_r <= entries[0].score;
            out_last_r  <= !entries[1].valid;
            if (!entries[1].valid) begin
              state_r <= ST_LOAD;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_id    = out_id_r;
  assign out_ch.out_score = out_score_r;
  assign out_ch.out_last  = out_last_r;

endmodule

`default_nettype wire

// File: test/tks_ranker_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class for the top-K selector testbench: keeps its own sorted bank
// and the queue of results still due. Depends on tks_pkg for the field widths.
package tks_ranker_pkg;

  localparam int KeepDepth = 10;

  typedef struct packed {
    logic [tks_pkg::IdW-1:0]           id;
    logic signed [tks_pkg::ScoreW-1:0] score;
    logic                              last;
  } winner_t;

  class top_k_ranker;
    logic [tks_pkg::IdW-1:0]           kept_ids[KeepDepth];
    logic signed [tks_pkg::ScoreW-1:0] kept_scores[KeepDepth];
    int                                kept_count = 0;
    winner_t                           due_winners[$];
    int                                errors = 0;

    // one line per mismatch
    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // item taken by the block: insert it, and on a last item queue the bank
    function void note_offer(logic [tks_pkg::IdW-1:0] id,
                             logic signed [tks_pkg::ScoreW-1:0] sc, logic lst);
      int pos;
      int slot;
      winner_t w;
      pos = kept_count;
      // ties stay behind the kept entry, so a full bank drops a tie to the weakest
      while (pos > 0 && kept_scores[pos-1] < sc) pos--;
      if (pos < KeepDepth) begin
        slot = (kept_count < KeepDepth) ? kept_count : KeepDepth - 1;
        while (slot > pos) begin
          kept_ids[slot]    = kept_ids[slot-1];
          kept_scores[slot] = kept_scores[slot-1];
          slot--;
        end
        kept_ids[pos]    = id;
        kept_scores[pos] = sc;
        if (kept_count < KeepDepth) kept_count++;
      end
      if (lst) begin
        for (int k = 0; k < kept_count; k++) begin
          w = '{kept_ids[k], kept_scores[k], k == kept_count - 1};
          due_winners = {due_winners, w};
        end
        kept_count = 0;
      end
    endfunction

    task check_result(logic [tks_pkg::IdW-1:0] id,
                      logic signed [tks_pkg::ScoreW-1:0] sc, logic lst);
      winner_t want;
      if (due_winners.size() == 0) begin
        report($sformatf("unexpected result id=%0d score=%0d last=%0b", id, sc, lst));
        return;
      end
      want = due_winners.pop_front();
      if (id !== want.id)
        report($sformatf("out_id %0d, expected %0d", id, want.id));
      if (sc !== want.score)
        report($sformatf("out_score %0d, expected %0d", sc, want.score));
      if (lst !== want.last)
        report($sformatf("out_last %0b, expected %0b", lst, want.last));
    endtask

    function int pending();
      return due_winners.size();
    endfunction
  endclass

endpackage

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for top_k_select_by_score_top: directed and random scored runs,
// random idling on both channels. Depends on tks_pkg, tks_if and tks_ranker_pkg.
module tb_top;

  typedef enum int {SpWide, SpNarrow, SpCorner} score_pattern_t;

  localparam int ItemTarget = 470;
  localparam int IdlePct    = 26;

  logic clk = 1'b0;
  logic rst_n;

  tks_in_if  in_ch();
  tks_out_if out_ch();

  top_k_select_by_score_top #(.TOP_K(tks_ranker_pkg::KeepDepth)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tks_ranker_pkg::top_k_ranker ranker = new();

  int items_sent = 0;
  // set for a stretch of the random part: neither side idles then
  logic calm = 1'b0;

  always #6 clk = ~clk;

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end

  // Result side: ready is redrawn every cycle; a result is taken at the
  // negedge before the rising edge that completes the handshake, so both
  // data and ready are settled when sampled.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= calm || ($urandom_range(0, 99) >= IdlePct);
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready)
      ranker.check_result(out_ch.out_id, out_ch.out_score, out_ch.out_last);
  end

  // Offer one item. Called at a rising edge; returns at the rising edge that
  // takes it. Random gaps go in front of the item, never inside a handshake.
  task automatic send_item(input logic [tks_pkg::IdW-1:0] id,
                           input logic signed [tks_pkg::ScoreW-1:0] sc,
                           input logic lst);
    while (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.place_id <= id;
    in_ch.score    <= sc;
    in_ch.last     <= lst;
    // ready may drop during a drain; decide acceptance on settled values
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    ranker.note_offer(id, sc, lst);
    @(posedge clk);
    items_sent++;
    calm = (items_sent >= 200 && items_sent < 300);
  endtask

  // One run with random content: short runs mostly, now and then longer
  // than the bank so that items get pushed out.
  task automatic send_random_run();
    int len;
    score_pattern_t pattern;
    logic signed [tks_pkg::ScoreW-1:0] sc;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 14);
    case ($urandom_range(0, 3))
      0, 1:    pattern = SpWide;
      2:       pattern = SpNarrow;
      default: pattern = SpCorner;
    endcase
    for (int i = 0; i < len; i++) begin
      case (pattern)
        SpWide: sc = 16'($urandom);
        SpNarrow: begin
          // small band around zero, so ties are common
          sc = 16'($urandom_range(0, 6));
          sc = sc - 16'sd3;
        end
        default: begin
          case ($urandom_range(0, 3))
            0:       sc = 16'sh7fff;
            1:       sc = 16'sh8000;
            2:       sc = '0;
            default: sc = '1;
          endcase
        end
      endcase
      send_item(10'($urandom_range(0, 1023)), sc, i == len - 1);
    end
  endtask

  initial begin
    // every input known from time zero
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.place_id = '0;
    in_ch.score    = '0;
    in_ch.last     = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a run of a single item at each extreme of id and score
    send_item(10'd1023, 16'sh7fff, 1'b1);
    send_item(10'd0, 16'sh8000, 1'b1);
    // twelve equal scores: arrival order kept, the last two only tie the
    // weakest of a full bank and stay out
    for (int i = 0; i < 12; i++)
      send_item(10'(i), 16'sd5, i == 11);
    // eleven alternating extremes: full bank, then a top score pushes out the last bottom entry
    for (int i = 0; i < 11; i++)
      send_item(10'(1023 - i), (i % 2 == 0) ? 16'sh7fff : 16'sh8000, i == 10);

    // Random runs until the item count is reached
    while (items_sent < ItemTarget) send_random_run();
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    // drain whatever is still due, then allow a little slack for stray results
    while (ranker.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (ranker.pending() != 0)
      ranker.report($sformatf("%0d results never arrived", ranker.pending()));

    if (ranker.errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
